// ===== rtl/core/rotor_cipher_letter_engine_defines.svh =====
// Assertion macros used by the rotor cipher letter engine sequencer.
`ifndef ROTOR_CIPHER_LETTER_ENGINE_DEFINES_SVH
`define ROTOR_CIPHER_LETTER_ENGINE_DEFINES_SVH

// Check that holds outside reset.
`define RCE_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rotor cipher engine check failed");

// Check that holds at every edge, reset included.
`define RCE_ASSERT_ANY(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rotor cipher engine reset check failed");

`endif

// ===== rtl/core/rce_pkg.sv =====
// Types, constants and letter arithmetic of the rotor cipher letter engine.
package rce_pkg;

    localparam int AlphabetSize = 26;
    localparam int LetterW      = 5;
    localparam int PlugPairs    = 10;
    localparam int PlugW        = PlugPairs * LetterW;
    localparam int NumRotors    = 3;
    localparam int NumTables    = 4;
    localparam int MemDepth     = NumTables * AlphabetSize;
    localparam int MemAddrW     = $clog2(MemDepth);
    localparam int StageW       = 3;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = PlugW;
    localparam int OpW          = 2;
    localparam int TblW         = 2;

    typedef logic [LetterW-1:0] letter_t;

    typedef enum logic [OpW-1:0] {
        OP_CIPHER  = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [TblW-1:0] {
        TBL_RIGHT     = 2'd0,
        TBL_MIDDLE    = 2'd1,
        TBL_LEFT      = 2'd2,
        TBL_REFLECTOR = 2'd3
    } tbl_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_RIGHT   = 3'd0,
        CFG_START_MIDDLE  = 3'd1,
        CFG_START_LEFT    = 3'd2,
        CFG_NOTCH_RIGHT   = 3'd3,
        CFG_NOTCH_MIDDLE  = 3'd4,
        CFG_NOTCH_LEFT    = 3'd5,
        CFG_PLUG_FIRST    = 3'd6,
        CFG_PLUG_SECOND   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARG,
        ST_FWAIT,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [OpW-1:0]  op;
        letter_t         letter;
        logic [TblW-1:0] table_sel;
        letter_t         entry_index;
        letter_t         entry_value;
    } in_item_t;

    typedef struct packed {
        letter_t cipher_letter;
        logic    wiring_fault;
    } out_item_t;

    typedef struct packed {
        letter_t [NumRotors-1:0] start_pos;
        letter_t [NumRotors-1:0] notch_phase;
        logic [PlugW-1:0]        plug_first;
        logic [PlugW-1:0]        plug_second;
    } cfg_t;

    typedef struct packed {
        logic                wr_en;
        logic [MemAddrW-1:0] wr_addr;
        letter_t             wr_data;
        logic                rd_en;
        logic [MemAddrW-1:0] rd_addr;
    } mem_req_t;

    // Reduce a raw five-bit value into the alphabet (value stays below twice the size).
    function automatic letter_t mod_letter(input letter_t x);
        letter_t r;
        r = (32'(x) >= AlphabetSize) ? letter_t'(32'(x) - AlphabetSize) : x;
        return r;
    endfunction

    function automatic letter_t wrap_add(input letter_t a, input letter_t b);
        logic [LetterW:0] s;
        s = {1'b0, mod_letter(a)} + {1'b0, mod_letter(b)};
        if (32'(s) >= AlphabetSize) begin
            s = s - (LetterW+1)'(AlphabetSize);
        end
        return s[LetterW-1:0];
    endfunction

    function automatic letter_t wrap_sub(input letter_t a, input letter_t b);
        logic [LetterW:0] s;
        s = {1'b0, mod_letter(a)} + (LetterW+1)'(AlphabetSize) - {1'b0, mod_letter(b)};
        if (32'(s) >= AlphabetSize) begin
            s = s - (LetterW+1)'(AlphabetSize);
        end
        return s[LetterW-1:0];
    endfunction

    // Pair swap on raw values: scan pairs in order, last match wins.
    function automatic letter_t plug_swap(input letter_t x, input logic [PlugW-1:0] first,
                                          input logic [PlugW-1:0] second);
        letter_t r;
        letter_t a;
        letter_t b;
        r = x;
        for (int i = 0; i < PlugPairs; i++) begin
            a = first[i*LetterW +: LetterW];
            b = second[i*LetterW +: LetterW];
            if (a == x) r = b;
            if (b == x) r = a;
        end
        return r;
    endfunction

    function automatic logic [MemAddrW-1:0] table_addr(input logic [TblW-1:0] tbl,
                                                        input letter_t idx);
        return MemAddrW'(tbl) * MemAddrW'(AlphabetSize) + MemAddrW'(idx);
    endfunction

endpackage

// ===== rtl/core/rotor_cipher_letter_engine.sv =====
// Top level of the rotor cipher letter engine.
//
// Usage: items enter on the s_ channel (valid/ready), one result per item
// leaves on the m_ channel (valid/ready). The op field selects the work:
// encipher a letter, load one wiring entry, or restart the rotor positions.
// Configuration registers (start positions, notch phases, plugboard pairs)
// are written through cfg_wr_en / cfg_index / cfg_wdata while the engine
// is idle; a write takes effect at the edge it is presented, no wait.
// The engine works on one item at a time. Load, restart and unused ops
// pass through the done state to the output register. A letter takes
// four forward lookups and three reverse searches, each search reading
// one wiring entry per cycle from the table memory's single read port;
// the length of the searches sets the time that a letter takes.
// Reset (aresetn low, synchronous) clears rotor positions, notch counters,
// configuration and the output valid flag; wiring tables stay undefined
// until loaded. When the receiver stalls, the result holds in the output
// register while the engine finishes its next item, then waits.
module rotor_cipher_letter_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rce_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rce_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [rce_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [rce_pkg::CfgDataW-1:0]    cfg_wdata
);

    rce_pkg::cfg_t      cfg_reg;
    rce_pkg::mem_req_t  mem_req;
    rce_pkg::letter_t   mem_rdata;
    logic               res_valid;
    logic               res_ready;
    rce_pkg::out_item_t res;
    logic               m_valid_reg;
    rce_pkg::out_item_t m_data_reg;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (rce_pkg::cfg_idx_t'(cfg_index))
                rce_pkg::CFG_START_RIGHT:  cfg_reg.start_pos[0]   <= cfg_wdata[4:0];
                rce_pkg::CFG_START_MIDDLE: cfg_reg.start_pos[1]   <= cfg_wdata[4:0];
                rce_pkg::CFG_START_LEFT:   cfg_reg.start_pos[2]   <= cfg_wdata[4:0];
                rce_pkg::CFG_NOTCH_RIGHT:  cfg_reg.notch_phase[0] <= cfg_wdata[4:0];
                rce_pkg::CFG_NOTCH_MIDDLE: cfg_reg.notch_phase[1] <= cfg_wdata[4:0];
                rce_pkg::CFG_NOTCH_LEFT:   cfg_reg.notch_phase[2] <= cfg_wdata[4:0];
                rce_pkg::CFG_PLUG_FIRST:   cfg_reg.plug_first     <= cfg_wdata;
                rce_pkg::CFG_PLUG_SECOND:  cfg_reg.plug_second    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: steps the rotors and walks the tables. Loads and reads
    // never overlap on one entry, since one item is in flight at a time.
    rce_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item_ready (s_ready),
        .item       (s_data),
        .cfg        (cfg_reg),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    rce_wiring_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Output register: take a result whenever the slot is free or draining.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/rce_wiring_mem.sv =====
// Wiring table memory: one write port, one registered read port.
module rce_wiring_mem (
    input  logic               aclk,
    input  rce_pkg::mem_req_t  req,
    output rce_pkg::letter_t   rdata
);

    rce_pkg::letter_t mem [rce_pkg::MemDepth];
    rce_pkg::letter_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rce_sequencer.sv =====
// Letter sequencer: rotor stepping, table walk and reverse searches.
`include "rotor_cipher_letter_engine_defines.svh"

module rce_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  rce_pkg::in_item_t   item,
    input  rce_pkg::cfg_t       cfg,
    output rce_pkg::mem_req_t   mem_req,
    input  rce_pkg::letter_t    mem_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output rce_pkg::out_item_t  res
);

    rce_pkg::seq_state_t state_reg, state_next;
    logic [rce_pkg::StageW-1:0] stage_reg, stage_next;
    rce_pkg::letter_t x_reg, x_next;
    rce_pkg::letter_t key_reg, key_next;
    rce_pkg::letter_t scan_idx_reg, scan_idx_next;
    logic pend_reg, pend_next;
    rce_pkg::letter_t pend_idx_reg, pend_idx_next;
    logic fault_reg, fault_next;
    rce_pkg::out_item_t res_reg, res_next;
    rce_pkg::letter_t [rce_pkg::NumRotors-1:0] pos_reg, pos_next;
    rce_pkg::letter_t [rce_pkg::NumRotors-1:0] steps_reg, steps_next;
    rce_pkg::letter_t [rce_pkg::NumRotors-1:0] notch_reg, notch_next;

    rce_pkg::letter_t prev_pos, next_pos, arg;
    logic [rce_pkg::TblW-1:0] tbl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rce_pkg::ST_IDLE;
            steps_reg <= '0;
            notch_reg <= '0;
        end else begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            notch_reg <= notch_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg    <= stage_next;
        x_reg        <= x_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        pend_reg     <= pend_next;
        pend_idx_reg <= pend_idx_next;
        fault_reg    <= fault_next;
        res_reg      <= res_next;
        pos_reg      <= pos_next;
    end

    // Per stage: leave the previous rotor frame, enter the next, pick the table.
    always_comb begin
        prev_pos = '0;
        next_pos = '0;
        tbl      = rce_pkg::TBL_RIGHT;
        case (stage_reg)
            3'd0: begin next_pos = pos_reg[0]; tbl = rce_pkg::TBL_RIGHT; end
            3'd1: begin
                prev_pos = pos_reg[0]; next_pos = pos_reg[1]; tbl = rce_pkg::TBL_MIDDLE;
            end
            3'd2: begin
                prev_pos = pos_reg[1]; next_pos = pos_reg[2]; tbl = rce_pkg::TBL_LEFT;
            end
            3'd3: begin prev_pos = pos_reg[2]; tbl = rce_pkg::TBL_REFLECTOR; end
            3'd4: begin next_pos = pos_reg[2]; tbl = rce_pkg::TBL_LEFT; end
            3'd5: begin
                prev_pos = pos_reg[2]; next_pos = pos_reg[1]; tbl = rce_pkg::TBL_MIDDLE;
            end
            3'd6: begin
                prev_pos = pos_reg[1]; next_pos = pos_reg[0]; tbl = rce_pkg::TBL_RIGHT;
            end
            default: begin prev_pos = pos_reg[0]; end
        endcase
        arg = rce_pkg::wrap_add(rce_pkg::wrap_sub(x_reg, prev_pos), next_pos);
    end

    always_comb begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        x_next        = x_reg;
        key_next      = key_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        fault_next    = fault_reg;
        res_next      = res_reg;
        pos_next      = pos_reg;
        steps_next    = steps_reg;
        notch_next    = notch_reg;
        mem_req       = '0;
        item_ready    = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            rce_pkg::ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    res_next  = '0;
                    state_next = rce_pkg::ST_DONE;
                    case (item.op)
                        rce_pkg::OP_CIPHER: begin
                            if (notch_reg[1] == '0) begin
                                notch_next[2] = rce_pkg::wrap_add(notch_reg[2], 5'd1);
                                steps_next[2] = rce_pkg::wrap_add(steps_reg[2], 5'd1);
                                notch_next[1] = rce_pkg::wrap_add(notch_reg[1], 5'd1);
                                steps_next[1] = rce_pkg::wrap_add(steps_reg[1], 5'd1);
                            end else if (notch_reg[0] == '0) begin
                                notch_next[1] = rce_pkg::wrap_add(notch_reg[1], 5'd1);
                                steps_next[1] = rce_pkg::wrap_add(steps_reg[1], 5'd1);
                            end
                            notch_next[0] = rce_pkg::wrap_add(notch_reg[0], 5'd1);
                            steps_next[0] = rce_pkg::wrap_add(steps_reg[0], 5'd1);
                            for (int k = 0; k < rce_pkg::NumRotors; k++) begin
                                pos_next[k] = rce_pkg::wrap_add(cfg.start_pos[k], steps_next[k]);
                            end
                            x_next     = rce_pkg::plug_swap(item.letter, cfg.plug_first,
                                                            cfg.plug_second);
                            stage_next = '0;
                            fault_next = 1'b0;
                            state_next = rce_pkg::ST_ARG;
                        end
                        rce_pkg::OP_LOAD: begin
                            if (32'(item.entry_index) < rce_pkg::AlphabetSize) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = rce_pkg::table_addr(item.table_sel,
                                                                      item.entry_index);
                                mem_req.wr_data = item.entry_value;
                            end
                        end
                        rce_pkg::OP_RESTART: begin
                            for (int k = 0; k < rce_pkg::NumRotors; k++) begin
                                steps_next[k] = '0;
                                notch_next[k] = rce_pkg::mod_letter(cfg.notch_phase[k]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rce_pkg::ST_ARG: begin
                if (stage_reg < 3'd4) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rce_pkg::table_addr(tbl, arg);
                    state_next      = rce_pkg::ST_FWAIT;
                end else if (stage_reg != 3'd7) begin
                    key_next      = arg;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    state_next    = rce_pkg::ST_SCAN;
                end else begin
                    res_next.cipher_letter = rce_pkg::plug_swap(arg, cfg.plug_first,
                                                                cfg.plug_second);
                    res_next.wiring_fault  = fault_reg;
                    state_next             = rce_pkg::ST_DONE;
                end
            end
            rce_pkg::ST_FWAIT: begin
                x_next     = mem_rdata;
                stage_next = stage_reg + 3'd1;
                state_next = rce_pkg::ST_ARG;
            end
            rce_pkg::ST_SCAN: begin
                // Compare the entry read last cycle while fetching the next one.
                if (pend_reg && mem_rdata == key_reg) begin
                    x_next     = pend_idx_reg;
                    stage_next = stage_reg + 3'd1;
                    state_next = rce_pkg::ST_ARG;
                end else if (pend_reg && 32'(pend_idx_reg) == rce_pkg::AlphabetSize - 1) begin
                    x_next     = '0;
                    fault_next = 1'b1;
                    stage_next = stage_reg + 3'd1;
                    state_next = rce_pkg::ST_ARG;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rce_pkg::table_addr(tbl, scan_idx_reg);
                    pend_next       = 1'b1;
                    pend_idx_next   = scan_idx_reg;
                    scan_idx_next   = scan_idx_reg + 5'd1;
                end
            end
            rce_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = rce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rce_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    `RCE_ASSERT_ANY(a_reset_to_idle, !aresetn |=> (state_reg == rce_pkg::ST_IDLE))
    `RCE_ASSERT_RST(a_fwait_after_read, (state_reg == rce_pkg::ST_FWAIT) |-> $past(mem_req.rd_en))
    `RCE_ASSERT_RST(a_scan_in_range, (state_reg == rce_pkg::ST_SCAN && pend_reg) |-> (32'(pend_idx_reg) < rce_pkg::AlphabetSize))
    `RCE_ASSERT_RST(a_write_on_accept, mem_req.wr_en |-> (state_reg == rce_pkg::ST_IDLE && item_valid))

endmodule

// ===== dv/testbench.sv =====
// Testbench for the rotor cipher letter engine: directed and random transactions checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int LimitCycles = 20000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    rce_pkg::in_item_t              s_data;
    logic                           m_valid;
    logic                           m_ready;
    rce_pkg::out_item_t             m_data;
    logic                           cfg_wr_en;
    logic [rce_pkg::CfgIdxW-1:0]    cfg_index;
    logic [rce_pkg::CfgDataW-1:0]   cfg_wdata;

    rotor_cipher_letter_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: a private copy of configuration, rotor state and wiring.
    rce_pkg::letter_t          pos_start [3];
    rce_pkg::letter_t          phase_notch [3];
    logic [rce_pkg::PlugW-1:0] plug_a;
    logic [rce_pkg::PlugW-1:0] plug_b;
    int unsigned               rotor_pos [3];
    int unsigned               notch_cnt [3];
    int unsigned               wiring [rce_pkg::NumTables*rce_pkg::AlphabetSize];

    rce_pkg::out_item_t        cipher_queue [$];
    int                        error_count;
    bit                        sender_busy_gaps;   // random idling on the sender side
    bit                        receiver_gaps;      // random stalls on the receiver side
    bit                        receiver_hold;      // long hold-off request
    int                        idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned add26(int unsigned a, int unsigned b);
        return (a % rce_pkg::AlphabetSize + b % rce_pkg::AlphabetSize) % rce_pkg::AlphabetSize;
    endfunction

    function automatic int unsigned sub26(int unsigned a, int unsigned b);
        return (a % rce_pkg::AlphabetSize + rce_pkg::AlphabetSize - b % rce_pkg::AlphabetSize)
               % rce_pkg::AlphabetSize;
    endfunction

    function automatic int unsigned swap_plug(int unsigned x);
        int unsigned r;
        int unsigned a;
        int unsigned b;
        r = x;
        for (int i = 0; i < rce_pkg::PlugPairs; i++) begin
            a = plug_a[i*rce_pkg::LetterW +: rce_pkg::LetterW];
            b = plug_b[i*rce_pkg::LetterW +: rce_pkg::LetterW];
            if (a == x) r = b;
            if (b == x) r = a;
        end
        return r;
    endfunction

    function automatic int unsigned search_back(int t, int unsigned x, ref bit miss);
        for (int i = 0; i < rce_pkg::AlphabetSize; i++)
            if (wiring[t*rce_pkg::AlphabetSize + i] == x) return i;
        miss = 1'b1;
        return 0;
    endfunction

    // Work out the result of one transaction and advance the predictor.
    function automatic rce_pkg::out_item_t encipher_predict(rce_pkg::in_item_t it);
        rce_pkg::out_item_t res;
        bit                 miss;
        int unsigned        x;
        int unsigned        p0, p1, p2;
        res  = '0;
        miss = 1'b0;
        if (it.op == rce_pkg::OP_LOAD) begin
            if (it.entry_index < rce_pkg::AlphabetSize) begin
                wiring[it.table_sel*rce_pkg::AlphabetSize + it.entry_index] = it.entry_value;
            end
            return res;
        end
        if (it.op == rce_pkg::OP_RESTART) begin
            for (int k = 0; k < 3; k++) begin
                rotor_pos[k] = 0;
                notch_cnt[k] = phase_notch[k] % rce_pkg::AlphabetSize;
            end
            return res;
        end
        if (it.op != rce_pkg::OP_CIPHER) return res;
        if (notch_cnt[1] == 0) begin
            notch_cnt[2] = add26(notch_cnt[2], 1);
            rotor_pos[2] = add26(rotor_pos[2], 1);
            notch_cnt[1] = add26(notch_cnt[1], 1);
            rotor_pos[1] = add26(rotor_pos[1], 1);
        end else if (notch_cnt[0] == 0) begin
            notch_cnt[1] = add26(notch_cnt[1], 1);
            rotor_pos[1] = add26(rotor_pos[1], 1);
        end
        notch_cnt[0] = add26(notch_cnt[0], 1);
        rotor_pos[0] = add26(rotor_pos[0], 1);
        p0 = add26(pos_start[0], rotor_pos[0]);
        p1 = add26(pos_start[1], rotor_pos[1]);
        p2 = add26(pos_start[2], rotor_pos[2]);
        x = swap_plug(it.letter);
        x = wiring[rce_pkg::TBL_RIGHT*rce_pkg::AlphabetSize + add26(x, p0)];
        x = wiring[rce_pkg::TBL_MIDDLE*rce_pkg::AlphabetSize + add26(sub26(x, p0), p1)];
        x = wiring[rce_pkg::TBL_LEFT*rce_pkg::AlphabetSize + add26(sub26(x, p1), p2)];
        x = wiring[rce_pkg::TBL_REFLECTOR*rce_pkg::AlphabetSize + sub26(x, p2)];
        x = search_back(rce_pkg::TBL_LEFT, add26(x, p2), miss);
        x = search_back(rce_pkg::TBL_MIDDLE, add26(sub26(x, p2), p1), miss);
        x = search_back(rce_pkg::TBL_RIGHT, add26(sub26(x, p1), p0), miss);
        x = swap_plug(sub26(x, p0));
        res.cipher_letter = rce_pkg::letter_t'(x);
        res.wiring_fault  = miss;
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(rce_pkg::cfg_idx_t idx, logic [rce_pkg::CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= rce_pkg::CFG_START_LEFT) pos_start[idx] = val[rce_pkg::LetterW-1:0];
        else if (idx <= rce_pkg::CFG_NOTCH_LEFT) phase_notch[idx-3] = val[rce_pkg::LetterW-1:0];
        else if (idx == rce_pkg::CFG_PLUG_FIRST) plug_a = val[rce_pkg::PlugW-1:0];
        else plug_b = val[rce_pkg::PlugW-1:0];
        @(posedge aclk);
    endtask

    // Offer one transaction and hold it until accepted.
    task automatic send_item(rce_pkg::in_item_t it);
        do @(posedge aclk); while (sender_busy_gaps && $urandom_range(99) < 25);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        cipher_queue.push_back(encipher_predict(it));
        s_valid <= 1'b0;
    endtask

    // Wait until every expected result has arrived, then let the engine settle.
    task automatic drain();
        while (cipher_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic rce_pkg::in_item_t cipher_item(rce_pkg::letter_t l);
        rce_pkg::in_item_t it;
        it        = '0;
        it.op     = rce_pkg::OP_CIPHER;
        it.letter = l;
        it.table_sel   = 2'($urandom);
        it.entry_index = 5'($urandom);
        it.entry_value = 5'($urandom);
        return it;
    endfunction

    function automatic rce_pkg::in_item_t load_item(int t, int i, int v);
        rce_pkg::in_item_t it;
        it = '0;
        it.op          = rce_pkg::OP_LOAD;
        it.letter      = 5'($urandom);
        it.table_sel   = 2'(t);
        it.entry_index = 5'(i);
        it.entry_value = 5'(v);
        return it;
    endfunction

    function automatic rce_pkg::in_item_t restart_item();
        rce_pkg::in_item_t it;
        it    = rce_pkg::in_item_t'($bits(rce_pkg::in_item_t)'($urandom));
        it.op = rce_pkg::OP_RESTART;
        return it;
    endfunction

    // Load all four tables; permutations mostly, sometimes with duplicate entries so
    // that reverse searches miss.
    task automatic load_wiring(bit broken);
        int perm [rce_pkg::AlphabetSize];
        int j, tmp;
        for (int t = 0; t < rce_pkg::NumTables; t++) begin
            for (int i = 0; i < rce_pkg::AlphabetSize; i++) perm[i] = i;
            for (int i = rce_pkg::AlphabetSize - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
            end
            if (broken) perm[$urandom_range(rce_pkg::AlphabetSize-1)] = $urandom_range(31);
            for (int i = 0; i < rce_pkg::AlphabetSize; i++)
                send_item(load_item(t, i, perm[i]));
        end
    endtask

    function automatic logic [rce_pkg::PlugW-1:0] random_plugs(bit wide);
        logic [rce_pkg::PlugW-1:0] v;
        for (int i = 0; i < rce_pkg::PlugPairs; i++)
            v[i*rce_pkg::LetterW +: rce_pkg::LetterW] =
                wide ? 5'($urandom) : 5'($urandom_range(25));
        return v;
    endfunction

    task automatic set_machine(int s0, int s1, int s2, int n0, int n1, int n2,
                               logic [rce_pkg::PlugW-1:0] pa,
                               logic [rce_pkg::PlugW-1:0] pb);
        write_reg(rce_pkg::CFG_START_RIGHT, s0);
        write_reg(rce_pkg::CFG_START_MIDDLE, s1);
        write_reg(rce_pkg::CFG_START_LEFT, s2);
        write_reg(rce_pkg::CFG_NOTCH_RIGHT, n0);
        write_reg(rce_pkg::CFG_NOTCH_MIDDLE, n1);
        write_reg(rce_pkg::CFG_NOTCH_LEFT, n2);
        write_reg(rce_pkg::CFG_PLUG_FIRST, pa);
        write_reg(rce_pkg::CFG_PLUG_SECOND, pb);
    endtask

    // Extremes of every field, every op, notch carries, misses and out-of-range loads.
    task automatic test_directed();
        rce_pkg::in_item_t it;
        load_wiring(1'b0);
        send_item(load_item(rce_pkg::TBL_LEFT, 31, 7));  // index beyond the alphabet: ignored
        send_item(load_item(rce_pkg::TBL_RIGHT, 26, 0));
        it = cipher_item(0);
        it.op = 2'd3;                           // unused op: no state change
        send_item(it);
        send_item(cipher_item(0));
        send_item(cipher_item(25));
        send_item(cipher_item(31));             // out-of-range letter
        send_item(restart_item());
        send_item(cipher_item(12));
        drain();
        // Notch counters near zero: double step of the middle rotor.
        set_machine(25, 25, 25, 25, 25, 31, {rce_pkg::PlugPairs{5'd31}},
                    {rce_pkg::PlugPairs{5'd0}});
        send_item(restart_item());
        for (int i = 0; i < 6; i++) send_item(cipher_item(5'($urandom)));
        send_item(cipher_item(31));             // plug pair with out-of-range letter
        send_item(cipher_item(0));
        send_item(load_item(rce_pkg::TBL_REFLECTOR, 3, 31));
        send_item(load_item(rce_pkg::TBL_MIDDLE, 0, 30));
        send_item(cipher_item(3));
        drain();
    endtask

    // Random settings, some out of range, and messages with random content, some noise.
    task automatic test_random();
        rce_pkg::in_item_t it;
        for (int phase = 0; phase < 8; phase++) begin
            set_machine($urandom_range(31), $urandom_range(31), $urandom_range(31),
                        $urandom_range(31), $urandom_range(31), $urandom_range(31),
                        random_plugs(phase % 3 == 0), random_plugs(phase % 4 == 1));
            if (phase % 4 == 0) load_wiring(phase == 4);
            send_item(restart_item());
            sender_busy_gaps = (phase != 3);
            receiver_gaps    = (phase != 3);
            for (int i = 0; i < 55; i++) begin
                if ($urandom_range(99) < 88) send_item(cipher_item(5'($urandom_range(25))));
                else if ($urandom_range(1)) begin
                    it = rce_pkg::in_item_t'($bits(rce_pkg::in_item_t)'($urandom));
                    it.entry_index = 5'($urandom_range(26, 31));
                    send_item(it);
                end else send_item(restart_item());
            end
            drain();
        end
        sender_busy_gaps = 1'b1;
        receiver_gaps    = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, then the sender waits.
    task automatic test_backpressure();
        receiver_hold = 1'b1;
        fork
            for (int i = 0; i < 20; i++) send_item(cipher_item(5'($urandom_range(25))));
            begin
                repeat (600) @(posedge aclk);
                receiver_hold = 1'b0;
            end
        join
        drain();
    endtask

    // Receiver: ready with random stalls, or held off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_hold && !(receiver_gaps && $urandom_range(99) < 25);
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        rce_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_queue.size() == 0) begin
                report_mismatch("unexpected result", m_data, 0);
            end else begin
                want = cipher_queue.pop_front();
                if (m_data.cipher_letter !== want.cipher_letter)
                    report_mismatch("cipher_letter", m_data.cipher_letter, want.cipher_letter);
                if (m_data.wiring_fault !== want.wiring_fault)
                    report_mismatch("wiring_fault", m_data.wiring_fault, want.wiring_fault);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > LimitCycles) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        m_ready          = 1'b0;
        idle_cycles      = 0;
        error_count      = 0;
        sender_busy_gaps = 1'b1;
        receiver_gaps    = 1'b1;
        receiver_hold    = 1'b0;
        plug_a           = '0;
        plug_b           = '0;
        for (int k = 0; k < 3; k++) begin
            pos_start[k] = 0; phase_notch[k] = 0; rotor_pos[k] = 0; notch_cnt[k] = 0;
        end
        for (int i = 0; i < rce_pkg::NumTables*rce_pkg::AlphabetSize; i++) begin
            wiring[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
